FILE: sv/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg
// Shared constants, register map and stage bundles of the interpolated
// table sampler.
// ----------------------------------------------------------------------------
package ist_pkg;

	// store geometry and fraction width
	localparam int TABLE_WORDS    = 1024;
	localparam int MAX_COMPONENTS = 4;
	localparam int FRACTION_BITS  = 16;
	localparam int ADDR_W         = $clog2(TABLE_WORDS);

	// clamped table position: 11-bit entry index and 16-bit fraction
	localparam int POS_W = 27;
	// flat word offset: entry index times stride plus component
	localparam int OFF_W = 14;

	// item codes
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// register indexes (byte address is four times the index)
	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_COUNT  = 3'd1;
	localparam logic [2:0] REG_STRIDE = 3'd2;
	localparam logic [2:0] REG_SCALE  = 3'd3;
	localparam logic [2:0] REG_BIAS   = 3'd4;

	localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

	// configuration as seen by the datapath
	typedef struct packed {
		logic               enable;
		logic [10:0]        count;
		logic [2:0]         stride;
		logic signed [31:0] scale;
		logic signed [31:0] bias;
	} cfg_t;

	// item leaving the position stage
	typedef struct packed {
		logic               vld;
		logic               cmd;
		logic               ok;
		logic [POS_W-1:0]   pos;
		logic [1:0]         comp;
		logic [9:0]         addr;
		logic signed [31:0] wval;
	} pos_item_t;

	// item leaving the store stage
	typedef struct packed {
		logic                     vld;
		logic                     ok;
		logic [FRACTION_BITS-1:0] alpha;
		logic signed [31:0]       rd_a;
		logic signed [31:0]       rd_b;
	} rd_item_t;

endpackage

FILE: sv/ist_pos.sv
// ----------------------------------------------------------------------------
// ist_pos
// Time to table position: scale multiply, then floor shift, bias add and
// clamp to the populated range, plus the table validity check.
// ----------------------------------------------------------------------------
module ist_pos import ist_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               cmd,
	input  logic signed [31:0] sample_time,
	input  logic [1:0]         component,
	input  logic [9:0]         word_address,
	input  logic signed [31:0] word_value,
	input  logic               nxt_ready,
	output pos_item_t          item
);

	logic               vld_s1;
	logic               cmd_s1;
	logic signed [63:0] prod_s1;
	logic [1:0]         comp_s1;
	logic [9:0]         addr_s1;
	logic signed [31:0] wval_s1;

	logic      ready_s1;
	logic      ready_s2;
	pos_item_t item_s2;

	logic signed [47:0] scaled;
	logic signed [48:0] biased;
	logic [10:0]        cnt_m1;
	logic [POS_W-1:0]   top;
	logic [POS_W-1:0]   pos_c;
	logic [13:0]        words;
	logic               tbl_ok;

	// stage readiness, back to front
	assign ready_s2  = !item_s2.vld || nxt_ready;
	assign ready_s1  = !vld_s1 || ready_s2;
	assign req_stall = !ready_s1;

	// stage 1: capture item and form the Q32.32 product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ready_s1) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			cmd_s1  <= cmd;
			prod_s1 <= sample_time * cfg.scale;
			comp_s1 <= component;
			addr_s1 <= word_address;
			wval_s1 <= word_value;
		end
	end

	// floor to Q32.16, add bias, clamp to [0, top]
	always_comb begin
		scaled = prod_s1[63:16];
		biased = 49'(scaled) + 49'(cfg.bias);
		cnt_m1 = cfg.count - 11'd1;
		top    = {cnt_m1, 16'h0000};
		if (biased[48]) begin
			pos_c = '0;
		end else if (biased > $signed({22'd0, top})) begin
			pos_c = top;
		end else begin
			pos_c = biased[POS_W-1:0];
		end
	end

	// table and component check
	always_comb begin
		words  = 14'(cfg.count) * 14'(cfg.stride);
		tbl_ok = cfg.enable && (cfg.count != 11'd0) && (cfg.stride != 3'd0) &&
			(32'(cfg.stride) <= 32'(MAX_COMPONENTS)) &&
			(32'(words) <= 32'(TABLE_WORDS)) && ({1'b0, comp_s1} < cfg.stride);
	end

	// stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s2 <= '0;
		end else if (ready_s2) begin
			item_s2.vld  <= vld_s1;
			item_s2.cmd  <= cmd_s1;
			item_s2.ok   <= tbl_ok;
			item_s2.pos  <= pos_c;
			item_s2.comp <= comp_s1;
			item_s2.addr <= addr_s1;
			item_s2.wval <= wval_s1;
		end
	end

	assign item = item_s2;

endmodule

FILE: sv/ist_store.sv
// ----------------------------------------------------------------------------
// ist_store
// Value store with one write and two read ports. Write items commit here in
// item order; sample items read both neighboring entries.
// ----------------------------------------------------------------------------
module ist_store import ist_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  pos_item_t item,
	output logic      ready,
	input  logic      nxt_ready,
	output rd_item_t  rd
);

	logic signed [31:0] mem_q [TABLE_WORDS];

	logic                     vld_s3;
	logic                     ok_s3;
	logic [FRACTION_BITS-1:0] alpha_s3;
	logic signed [31:0]       rda_s3;
	logic signed [31:0]       rdb_s3;

	logic [10:0]              idx_a;
	logic [10:0]              idx_b;
	logic [10:0]              cnt_m1;
	logic [OFF_W-1:0]         off_a;
	logic [OFF_W-1:0]         off_b;
	logic [23:0]              frac_w;
	logic [FRACTION_BITS-1:0] alpha;

	assign ready = !vld_s3 || nxt_ready;

	// neighbor addresses and interpolation weight
	always_comb begin
		cnt_m1 = cfg.count - 11'd1;
		idx_a  = item.pos[POS_W-1:16];
		idx_b  = (idx_a >= cnt_m1) ? cnt_m1 : idx_a + 11'd1;
		off_a  = OFF_W'(idx_a) * OFF_W'(cfg.stride) + OFF_W'(item.comp);
		off_b  = OFF_W'(idx_b) * OFF_W'(cfg.stride) + OFF_W'(item.comp);
		frac_w = {item.pos[15:0], 8'h00} >> (24 - FRACTION_BITS);
		alpha  = frac_w[FRACTION_BITS-1:0];
	end

	// store write and registered reads
	always_ff @(posedge clk) begin
		if (ready && item.vld && item.cmd == CMD_WRITE) begin
			mem_q[item.addr[ADDR_W-1:0]] <= item.wval;
		end
		if (ready) begin
			rda_s3 <= mem_q[off_a[ADDR_W-1:0]];
			rdb_s3 <= mem_q[off_b[ADDR_W-1:0]];
		end
	end

	// stage 3 control; write items end here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (ready) begin
			vld_s3 <= item.vld && (item.cmd == CMD_SAMPLE);
		end
	end

	always_ff @(posedge clk) begin
		if (ready) begin
			ok_s3    <= item.ok;
			alpha_s3 <= alpha;
		end
	end

	assign rd = {vld_s3, ok_s3, alpha_s3, rda_s3, rdb_s3};

endmodule

FILE: sv/ist_lerp.sv
// ----------------------------------------------------------------------------
// ist_lerp
// Linear blend of the two neighbors and the result register toward the
// receiver.
// ----------------------------------------------------------------------------
module ist_lerp import ist_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  rd_item_t           rd,
	output logic               ready,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [31:0] sample_value,
	output logic               sample_valid
);

	localparam int PROD_W = 33 + FRACTION_BITS + 1;

	logic                      vld_s4;
	logic                      ok_s4;
	logic signed [31:0]        a_s4;
	logic signed [PROD_W-1:0]  prod_s4;

	logic                      vld_q;
	logic signed [31:0]        value_q;
	logic                      ok_q;

	logic                      ready_s4;
	logic                      ready_out;
	logic signed [32:0]        diff;
	logic signed [PROD_W-1:0]  delta;
	logic signed [31:0]        blend;

	assign ready_out = !vld_q || !rsp_stall;
	assign ready_s4  = !vld_s4 || ready_out;
	assign ready     = ready_s4;

	// stage 4: weighted difference
	assign diff = 33'(rd.rd_b) - 33'(rd.rd_a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (ready_s4) begin
			vld_s4 <= rd.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4) begin
			ok_s4   <= rd.ok;
			a_s4    <= rd.rd_a;
			prod_s4 <= diff * $signed({1'b0, rd.alpha});
		end
	end

	// floor shift and add to the lower neighbor
	always_comb begin
		delta = prod_s4 >>> FRACTION_BITS;
		blend = a_s4 + delta[31:0];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ready_out) begin
			vld_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out) begin
			ok_q    <= ok_s4;
			value_q <= ok_s4 ? blend : 32'sd0;
		end
	end

	assign rsp_valid    = vld_q;
	assign sample_value = value_q;
	assign sample_valid = ok_q;

endmodule

FILE: sv/interpolated_table_sampler_top.sv
// ----------------------------------------------------------------------------
// interpolated_table_sampler_top
// Linear interpolation lookup over a table of up to four-component entries.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries one item per accept.
//   cmd 0 writes word_value at word_address and gives no result; cmd 1
//   samples component at sample_time and gives exactly one result on the
//   response channel (rsp_valid / rsp_stall): sample_value, sample_valid.
//   A sample passes the multiply, position, store read, blend and result
//   registers in that order.
//   Throughput: one item per cycle while req_stall is low, set by the two-read
//   one-write store serving both neighbors and the write in the same cycle.
//   Writes commit in item order at the store stage, so a sample accepted
//   after a write sees that word.
//   When the receiver stalls, the result holds and the pipeline keeps
//   filling its empty stages; req_stall rises once every stage is occupied.
//   Reset clears all valid flags and the registers (scale 1.0); store contents
//   are undefined until written, and no clearing pass runs. The user must write
//   registers over the APB port only while no item is in flight; not enforced.
// ----------------------------------------------------------------------------
module interpolated_table_sampler_top import ist_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// request channel
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               cmd,
	input  logic signed [31:0] sample_time,
	input  logic [1:0]         component,
	input  logic [9:0]         word_address,
	input  logic signed [31:0] word_value,
	// response channel
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [31:0] sample_value,
	output logic               sample_valid
);

	cfg_t      cfg_q;
	pos_item_t pos_item;
	rd_item_t  rd_item;
	logic      store_ready;
	logic      lerp_ready;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b0;
			cfg_q.count  <= '0;
			cfg_q.stride <= '0;
			cfg_q.scale  <= SCALE_RESET;
			cfg_q.bias   <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_ENABLE: cfg_q.enable <= pwdata[0];
				REG_COUNT:  cfg_q.count  <= pwdata[10:0];
				REG_STRIDE: cfg_q.stride <= pwdata[2:0];
				REG_SCALE:  cfg_q.scale  <= pwdata;
				REG_BIAS:   cfg_q.bias   <= pwdata;
				default:    ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_ENABLE: prdata = {31'd0, cfg_q.enable};
			REG_COUNT:  prdata = {21'd0, cfg_q.count};
			REG_STRIDE: prdata = {29'd0, cfg_q.stride};
			REG_SCALE:  prdata = cfg_q.scale;
			REG_BIAS:   prdata = cfg_q.bias;
			default:    prdata = '0;
		endcase
	end

	ist_pos u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.cmd          (cmd),
		.sample_time  (sample_time),
		.component    (component),
		.word_address (word_address),
		.word_value   (word_value),
		.nxt_ready    (store_ready),
		.item         (pos_item)
	);

	ist_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item      (pos_item),
		.ready     (store_ready),
		.nxt_ready (lerp_ready),
		.rd        (rd_item)
	);

	ist_lerp u_lerp (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd           (rd_item),
		.ready        (lerp_ready),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.sample_value (sample_value),
		.sample_valid (sample_valid)
	);

endmodule

FILE: sv/ist_checker.sv
// ----------------------------------------------------------------------------
// ist_checker
// Port-level checks of the interpolated table sampler, bound to the top.
// ----------------------------------------------------------------------------
module ist_checker import ist_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               psel,
	input logic               penable,
	input logic               pready,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic signed [31:0] sample_value,
	input logic               sample_valid
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(sample_value) &&
		$stable(sample_valid))
		else $error("stalled result changed");

	// an invalid result carries zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !sample_valid |-> sample_value == 32'sd0)
		else $error("invalid result is not zero");

	// back-pressure only while the result register is held by the receiver
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without a held result");

	// register accesses never wait
	a_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable |-> pready)
		else $error("configuration access waited");

endmodule

bind interpolated_table_sampler_top ist_checker u_ist_checker (.*);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the interpolated table sampler. Table words are
// written through the request channel, samples are predicted in a scoreboard
// that keeps its own copy of the store and the registers, and every result is
// compared with the oldest prediction. Directed corners come first, then
// random items under fixed and random register settings, idle cycles on both
// channels, a long response hold-off and a stretch with no idle cycles.
// ----------------------------------------------------------------------------
module tb_top import ist_pkg::*;;

	localparam int      HALF_PERIOD  = 10;
	localparam int      DRAIN_CYCLES = 8;
	localparam int      HOLD_CYCLES  = 300;
	localparam int      PHASE_ITEMS  = 60;
	localparam int      RAND_PHASES  = 12;
	localparam longint  POS_MAX      = 64'sd2147483647;
	localparam longint  POS_MIN      = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] value;
		logic               valid;
	} sample_t;

	// predicted samples, store copy and register copy
	class sampler_scoreboard;
		cfg_t               cfg;
		logic signed [31:0] table_words [TABLE_WORDS];
		sample_t            expected_samples [$];
		int                 errors;
		int                 writes_seen;
		int                 samples_seen;
		int                 valid_seen;

		function new();
			cfg.enable = 1'b0;
			cfg.count  = '0;
			cfg.stride = '0;
			cfg.scale  = SCALE_RESET;
			cfg.bias   = '0;
			errors       = 0;
			writes_seen  = 0;
			samples_seen = 0;
			valid_seen   = 0;
		endfunction

		task report(string msg);
			if (errors < 50) $display("ERROR: %s", msg);
			errors++;
		endtask

		// table position of a sample: word offsets of both neighbors and the blend weight
		function bit locate(logic signed [31:0] t, logic [1:0] comp,
				output int off_a, output int off_b, output longint alpha);
			logic signed [31:0] scl;
			logic signed [31:0] bs;
			longint             prod;
			longint             pos;
			longint             top;
			int                 cnt;
			int                 str;
			int                 ia;
			int                 ib;
			off_a = 0;
			off_b = 0;
			alpha = 0;
			cnt = cfg.count;
			str = cfg.stride;
			scl = cfg.scale;
			bs  = cfg.bias;
			if (!cfg.enable || cnt == 0 || str == 0 || str > MAX_COMPONENTS ||
					cnt * str > TABLE_WORDS || int'(comp) >= str)
				return 1'b0;
			prod = longint'(t) * longint'(scl);
			pos = (prod >>> 16) + longint'(bs);
			if (pos > POS_MAX) pos = POS_MAX;
			if (pos < POS_MIN) pos = POS_MIN;
			top = (longint'(cnt) - 1) * 65536;
			if (pos < 0) pos = 0;
			if (pos > top) pos = top;
			ia = int'(pos >>> 16);
			ib = ia + 1;
			if (ib > cnt - 1) ib = cnt - 1;
			alpha = ((pos & 64'hffff) << 8) >> (24 - FRACTION_BITS);
			off_a = ia * str + int'(comp);
			off_b = ib * str + int'(comp);
			return 1'b1;
		endfunction

		// accepted item: store a word or predict one sample
		function void note_item(logic c, logic signed [31:0] t, logic [1:0] comp,
				logic [9:0] addr, logic signed [31:0] val);
			int      oa;
			int      ob;
			longint  alpha;
			longint  a;
			longint  b;
			longint  delta;
			sample_t want;
			if (c == CMD_WRITE) begin
				table_words[addr] = val;
				writes_seen++;
				return;
			end
			samples_seen++;
			want.value = '0;
			want.valid = 1'b0;
			if (locate(t, comp, oa, ob, alpha)) begin
				a = longint'(table_words[oa]);
				b = longint'(table_words[ob]);
				delta = ((b - a) * alpha) >>> FRACTION_BITS;
				want.value = 32'(a + delta);
				want.valid = 1'b1;
			end
			expected_samples.push_back(want);
		endfunction

		task check_sample(logic signed [31:0] value, logic valid);
			sample_t want;
			if (expected_samples.size() == 0) begin
				report($sformatf("result with nothing pending: value %0d valid %b",
					value, valid));
				return;
			end
			want = expected_samples.pop_front();
			if (valid !== want.valid)
				report($sformatf("sample_valid %b, predicted %b", valid, want.valid));
			if (value !== want.value)
				report($sformatf("sample_value %0d, predicted %0d", value, want.value));
			if (valid === 1'b1) valid_seen++;
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [4:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               req_valid;
	logic               req_stall;
	logic               cmd;
	logic signed [31:0] sample_time;
	logic [1:0]         component;
	logic [9:0]         word_address;
	logic signed [31:0] word_value;
	logic               rsp_valid;
	logic               rsp_stall;
	logic signed [31:0] sample_value;
	logic               sample_valid;

	sampler_scoreboard sb;
	bit                written [TABLE_WORDS];
	bit                calm = 1'b0;
	bit                holdoff_req = 1'b0;
	int                settings_used = 0;

	interpolated_table_sampler_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.cmd          (cmd),
		.sample_time  (sample_time),
		.component    (component),
		.word_address (word_address),
		.word_value   (word_value),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.sample_value (sample_value),
		.sample_valid (sample_valid)
	);

	always #HALF_PERIOD clk = ~clk;

	// run limit
	initial begin
		#5_000_000;
		$display("interpolated_table_sampler_top: mismatch");
		$finish;
	end

	// response side: random stalls, a counted hold-off on request
	initial begin : rsp_side
		int hold_left;
		hold_left = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_req) begin
				hold_left = HOLD_CYCLES;
				holdoff_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= !calm && ($urandom_range(99) < 36);
			end
		end
	end

	// result checking
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
			sb.check_sample(sample_value, sample_valid);
	end

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(7))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return 32'sh0000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic cfg_t make_cfg(bit en, int cnt, int str, int scl, int bs);
		cfg_t c;
		c.enable = en;
		c.count  = cnt[10:0];
		c.stride = str[2:0];
		c.scale  = scl;
		c.bias   = bs;
		return c;
	endfunction

	// mostly usable tables, small ones favored, now and then a broken setting
	function automatic cfg_t random_cfg();
		int str;
		int cnt;
		int scl;
		int bs;
		bit en;
		str = $urandom_range(1, MAX_COMPONENTS);
		cnt = ($urandom_range(3) == 0) ? $urandom_range(1, TABLE_WORDS / str)
			: $urandom_range(1, 16);
		case ($urandom_range(3))
			0: scl = 65536;
			1: begin
				scl = int'($urandom_range(0, 1 << 18));
				if ($urandom_range(1)) scl = -scl;
			end
			default: scl = $urandom;
		endcase
		case ($urandom_range(3))
			0: bs = 0;
			1: bs = int'($urandom_range(0, cnt << 16));
			2: bs = -int'($urandom_range(0, cnt << 16));
			default: bs = $urandom;
		endcase
		en = ($urandom_range(15) != 0);
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(2))
				0: str = 0;
				1: str = $urandom_range(MAX_COMPONENTS + 1, 7);
				default: cnt = ($urandom_range(1)) ? 0 : 2047;
			endcase
		end
		return make_cfg(en, cnt, str, scl, bs);
	endfunction

	// offer one item, wait for its accept, note it
	task automatic offer(logic c, logic signed [31:0] t, logic [1:0] comp,
			logic [9:0] addr, logic signed [31:0] val);
		int gap;
		gap = 0;
		while (!calm && $urandom_range(99) < 36) gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid    <= 1'b1;
		cmd          <= c;
		sample_time  <= t;
		component    <= comp;
		word_address <= addr;
		word_value   <= val;
		do @(posedge clk); while (req_stall !== 1'b0);
		sb.note_item(c, t, comp, addr, val);
	endtask

	task automatic write_word(int addr, logic signed [31:0] val);
		offer(CMD_WRITE, $urandom, 2'($urandom_range(3)), addr[9:0], val);
		written[addr] = 1'b1;
	endtask

	// sample, first filling any neighbor word that was never written
	task automatic sample_at(logic signed [31:0] t, logic [1:0] comp);
		int     oa;
		int     ob;
		longint alpha;
		if (sb.locate(t, comp, oa, ob, alpha)) begin
			if (!written[oa]) write_word(oa, rand_word());
			if (!written[ob]) write_word(ob, rand_word());
		end
		offer(CMD_SAMPLE, t, comp, 10'($urandom), $urandom);
	endtask

	// wait until every result is in and trailing writes have committed
	task automatic settle();
		req_valid <= 1'b0;
		while (sb.expected_samples.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] idx, logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(cfg_t c);
		settle();
		apb_write(REG_ENABLE, {31'd0, c.enable});
		apb_write(REG_COUNT, {21'd0, c.count});
		apb_write(REG_STRIDE, {29'd0, c.stride});
		apb_write(REG_SCALE, c.scale);
		apb_write(REG_BIAS, c.bias);
		sb.cfg = c;
		settings_used++;
	endtask

	// random item: some writes, mostly samples aimed inside the table
	task automatic random_item();
		int                 cnt;
		int                 str;
		logic signed [31:0] scl;
		logic signed [31:0] bs;
		longint             p;
		longint             num;
		logic signed [31:0] t;
		logic [1:0]         comp;
		cnt = sb.cfg.count;
		str = sb.cfg.stride;
		scl = sb.cfg.scale;
		bs  = sb.cfg.bias;
		if ($urandom_range(99) < 20) begin
			write_word($urandom_range(TABLE_WORDS - 1), rand_word());
			return;
		end
		if ($urandom_range(99) < 70 && scl != 0) begin
			p = longint'($urandom_range(0, (cnt + 1) << 16)) - 32768;
			num = ((p - longint'(bs)) * 65536) / longint'(scl);
			if (num > POS_MAX) num = POS_MAX;
			if (num < POS_MIN) num = POS_MIN;
			t = 32'(num);
		end else begin
			t = $urandom;
		end
		if (str >= 1 && str <= MAX_COMPONENTS && $urandom_range(9) != 0)
			comp = 2'($urandom_range(0, str - 1));
		else
			comp = 2'($urandom_range(3));
		sample_at(t, comp);
	endtask

	initial begin : stimulus
		int phase;
		int k;
		sb = new();
		arst_n       <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		req_valid    <= 1'b0;
		cmd          <= CMD_WRITE;
		sample_time  <= '0;
		component    <= '0;
		word_address <= '0;
		word_value   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers leave the table disabled
		sample_at(32'sh0001_0000, 2'd0);
		write_word(0, 32'sh8000_0000);
		write_word(TABLE_WORDS - 1, 32'sh7fff_ffff);

		// four entries of four components, widest neighbor difference
		configure(make_cfg(1, 4, 4, 65536, 0));
		write_word(4, 32'sh7fff_ffff);
		sample_at(32'sh0000_8000, 2'd0);
		sample_at(32'sh0001_ffff, 2'd0);
		sample_at(32'sh0003_0000, 2'd3);
		sample_at(32'sh7fff_ffff, 2'd1);
		sample_at(32'sh8000_0000, 2'd2);
		sample_at(32'sh0000_0000, 2'd0);

		// component not below stride
		configure(make_cfg(1, 3, 2, 65536, 0));
		sample_at(32'sh0000_8000, 2'd3);
		sample_at(32'sh0000_8000, 2'd1);
		sample_at(32'sh0001_8000, 2'd2);

		// single entry: both neighbors are the last entry
		configure(make_cfg(1, 1, 3, 65536, 32'sh0000_8000));
		sample_at(32'sh0001_2345, 2'd2);

		// extreme scale and bias: position clamps at both ends of the table
		configure(make_cfg(1, 8, 1, 32'sh7fff_ffff, 32'sh7fff_ffff));
		sample_at(32'sh7fff_ffff, 2'd0);
		sample_at(32'sh8000_0000, 2'd0);
		configure(make_cfg(1, 8, 1, 32'sh8000_0000, 32'sh8000_0000));
		sample_at(32'sh7fff_ffff, 2'd0);
		sample_at(32'sh8000_0000, 2'd0);

		// unusable tables
		configure(make_cfg(0, 8, 1, 65536, 0));
		sample_at(32'sh0001_0000, 2'd0);
		configure(make_cfg(1, 0, 1, 65536, 0));
		sample_at(32'sh0001_0000, 2'd0);
		configure(make_cfg(1, 8, 0, 65536, 0));
		sample_at(32'sh0001_0000, 2'd0);
		configure(make_cfg(1, 8, 5, 65536, 0));
		sample_at(32'sh0001_0000, 2'd0);
		configure(make_cfg(1, 8, 7, 65536, 0));
		sample_at(32'sh0001_0000, 2'd0);
		configure(make_cfg(1, 1024, 2, 65536, 0));
		sample_at(32'sh0001_0000, 2'd0);
		configure(make_cfg(1, 2047, 1, 65536, 0));
		sample_at(32'sh0001_0000, 2'd0);

		// random phases, one register setting each
		for (phase = 0; phase < RAND_PHASES; phase++) begin
			case (phase)
				0: configure(make_cfg(1, TABLE_WORDS, 1, 32'sh0000_8000, 0));
				1: configure(make_cfg(1, TABLE_WORDS / MAX_COMPONENTS, MAX_COMPONENTS,
					-212992, 32'sh00ff_0000));
				2: configure(make_cfg(1, 2, 4, 65536, 0));
				default: configure(random_cfg());
			endcase
			if (phase == 3) holdoff_req = 1'b1;
			calm = (phase == 6);
			for (k = 0; k < PHASE_ITEMS; k++) random_item();
			calm = 1'b0;
		end

		settle();
		$display("run covered %0d table writes and %0d samples (%0d valid) over %0d settings",
			sb.writes_seen, sb.samples_seen, sb.valid_seen, settings_used);
		$display("with random idle cycles, a long response hold-off and an idle-free stretch");
		if (sb.errors == 0)
			$display("interpolated_table_sampler_top: match");
		else
			$display("interpolated_table_sampler_top: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
sv/ist_pkg.sv
sv/ist_pos.sv
sv/ist_store.sv
sv/ist_lerp.sv
sv/interpolated_table_sampler_top.sv
sv/ist_checker.sv
tb/sv/tb_top.sv
